// ----- sv/ppf_pkg.sv -----
// shared types and constants for the pair potential and force core
package ppf_pkg;

  localparam int PAIR_W  = 60;
  localparam int FIELD_W = 20;
  localparam int DIST_W  = 24;
  localparam int OUT_W   = 48;
  localparam int CFG_W   = 60;
  localparam int IDX_W   = 3;

  localparam logic [IDX_W-1:0] REG_PAIR_AA   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PAIR_BB   = 3'd1;
  localparam logic [IDX_W-1:0] REG_PAIR_CC   = 3'd2;
  localparam logic [IDX_W-1:0] REG_PAIR_AB   = 3'd3;
  localparam logic [IDX_W-1:0] REG_PAIR_BC   = 3'd4;
  localparam logic [IDX_W-1:0] REG_PAIR_CA   = 3'd5;
  localparam logic [IDX_W-1:0] REG_SCALE     = 3'd6;
  localparam logic [IDX_W-1:0] REG_EXPONENTS = 3'd7;

  localparam logic [1:0] SPECIES_A = 2'd1;
  localparam logic [1:0] SPECIES_B = 2'd2;
  localparam logic [1:0] SPECIES_C = 2'd3;

  localparam logic [FIELD_W-1:0] SCALE_RESET = 20'd4096;
  localparam logic [9:0]         EXPO_RESET  = 10'd390;

  localparam logic signed [OUT_W-1:0] LIM47     = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [OUT_W-1:0] NEG_LIM47 = 48'sh8000_0000_0001;
  localparam logic [62:0] POW_CAP  = '1;
  localparam logic [56:0] TERM_CAP = '1;

  typedef struct packed {
    logic signed [OUT_W-1:0] energy;
    logic signed [OUT_W-1:0] slope;
    logic                    sat;
  } res_t;

endpackage

// ----- sv/ppf_divpipe.sv -----
// pipelined restoring divider, a few quotient bits per stage
module ppf_divpipe #(
  parameter int DEN_W  = 24,
  parameter int Q_W    = 56,
  parameter int BPS    = 4,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [Q_W-1:0]    in_lo,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int ST = (Q_W + BPS - 1) / BPS;

  logic              v_link    [0:ST];
  logic [DEN_W-1:0]  rem_link  [0:ST];
  logic [Q_W-1:0]    lo_link   [0:ST];
  logic [DEN_W-1:0]  den_link  [0:ST];
  logic [SIDE_W-1:0] side_link [0:ST];

  assign v_link[0]    = in_valid;
  assign rem_link[0]  = in_rem;
  assign lo_link[0]   = in_lo;
  assign den_link[0]  = in_den;
  assign side_link[0] = in_side;

  for (genvar s = 0; s < ST; s++) begin : g_stage
    logic [DEN_W-1:0]  rem_nxt;
    logic [Q_W-1:0]    lo_nxt;
    logic [DEN_W:0]    trial;
    logic              v_r;
    logic [DEN_W-1:0]  rem_r;
    logic [Q_W-1:0]    lo_r;
    logic [DEN_W-1:0]  den_r;
    logic [SIDE_W-1:0] side_r;

    always_comb begin
      rem_nxt = rem_link[s];
      lo_nxt  = lo_link[s];
      trial   = '0;
      for (int j = 0; j < BPS; j++) begin
        if (s * BPS + j < Q_W) begin
          trial = {rem_nxt, lo_nxt[Q_W-1]};
          if (trial >= {1'b0, den_link[s]}) begin
            trial  = trial - {1'b0, den_link[s]};
            lo_nxt = {lo_nxt[Q_W-2:0], 1'b1};
          end else begin
            lo_nxt = {lo_nxt[Q_W-2:0], 1'b0};
          end
          rem_nxt = trial[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_link[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_nxt;
        lo_r   <= lo_nxt;
        den_r  <= den_link[s];
        side_r <= side_link[s];
      end
    end

    assign v_link[s+1]    = v_r;
    assign rem_link[s+1]  = rem_r;
    assign lo_link[s+1]   = lo_r;
    assign den_link[s+1]  = den_r;
    assign side_link[s+1] = side_r;
  end

  assign out_valid = v_link[ST];
  assign out_quot  = lo_link[ST];
  assign out_side  = side_link[ST];

endmodule

// ----- sv/ppf_powpipe.sv -----
// two-lane power chain, one saturating q32 multiply step per two stages
module ppf_powpipe #(
  parameter int STEPS  = 31,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       in_x,
  input  logic [4:0]        exp_m,
  input  logic [4:0]        exp_n,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [62:0]       out_pm,
  output logic [62:0]       out_pn,
  output logic              out_ovf,
  output logic [SIDE_W-1:0] out_side
);
  import ppf_pkg::*;

  logic              v_link    [0:STEPS];
  logic [63:0]       x_link    [0:STEPS];
  logic [62:0]       pm_link   [0:STEPS];
  logic [62:0]       pn_link   [0:STEPS];
  logic              ovf_link  [0:STEPS];
  logic [SIDE_W-1:0] side_link [0:STEPS];

  assign v_link[0]    = in_valid;
  assign x_link[0]    = in_x;
  assign pm_link[0]   = 63'd4294967296;
  assign pn_link[0]   = 63'd4294967296;
  assign ovf_link[0]  = 1'b0;
  assign side_link[0] = in_side;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [5:0] STEP_IDX = 6'(k);

    logic              va_r;
    logic [63:0]       xa_r;
    logic [62:0]       pma_r, pna_r;
    logic              ovfa_r;
    logic [SIDE_W-1:0] sa_r;
    logic [63:0]       mll_r, mlh_r, nll_r, nlh_r;
    logic [62:0]       mhl_r, mhh_r, nhl_r, nhh_r;

    logic [127:0]      mprod, nprod;
    logic [95:0]       mq, nq;
    logic              mact, nact, mcap, ncap;
    logic [62:0]       pm_nxt, pn_nxt;
    logic              ovf_nxt;

    logic              vb_r;
    logic [63:0]       xb_r;
    logic [62:0]       pmb_r, pnb_r;
    logic              ovfb_r;
    logic [SIDE_W-1:0] sb_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        va_r <= 1'b0;
        vb_r <= 1'b0;
      end else if (en) begin
        va_r <= v_link[k];
        vb_r <= va_r;
      end
    end

    // partial products
    always_ff @(posedge clk) begin
      if (en) begin
        xa_r   <= x_link[k];
        pma_r  <= pm_link[k];
        pna_r  <= pn_link[k];
        ovfa_r <= ovf_link[k];
        sa_r   <= side_link[k];
        mll_r  <= pm_link[k][31:0] * x_link[k][31:0];
        mlh_r  <= pm_link[k][31:0] * x_link[k][63:32];
        mhl_r  <= pm_link[k][62:32] * x_link[k][31:0];
        mhh_r  <= pm_link[k][62:32] * x_link[k][63:32];
        nll_r  <= pn_link[k][31:0] * x_link[k][31:0];
        nlh_r  <= pn_link[k][31:0] * x_link[k][63:32];
        nhl_r  <= pn_link[k][62:32] * x_link[k][31:0];
        nhh_r  <= pn_link[k][62:32] * x_link[k][63:32];
      end
    end

    always_comb begin
      mprod = 128'(mll_r) + (128'(mlh_r) << 32) + (128'(mhl_r) << 32) + (128'(mhh_r) << 64);
      nprod = 128'(nll_r) + (128'(nlh_r) << 32) + (128'(nhl_r) << 32) + (128'(nhh_r) << 64);
      mq    = mprod[127:32];
      nq    = nprod[127:32];
      mcap  = mq > {33'b0, POW_CAP};
      ncap  = nq > {33'b0, POW_CAP};
      mact  = STEP_IDX < {1'b0, exp_m};
      nact  = STEP_IDX < {1'b0, exp_n};
      pm_nxt = !mact ? pma_r : (mcap ? POW_CAP : mq[62:0]);
      pn_nxt = !nact ? pna_r : (ncap ? POW_CAP : nq[62:0]);
      ovf_nxt = ovfa_r | (mact & mcap) | (nact & ncap);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xb_r   <= xa_r;
        pmb_r  <= pm_nxt;
        pnb_r  <= pn_nxt;
        ovfb_r <= ovf_nxt;
        sb_r   <= sa_r;
      end
    end

    assign v_link[k+1]    = vb_r;
    assign x_link[k+1]    = xb_r;
    assign pm_link[k+1]   = pmb_r;
    assign pn_link[k+1]   = pnb_r;
    assign ovf_link[k+1]  = ovfb_r;
    assign side_link[k+1] = sb_r;
  end

  assign out_valid = v_link[STEPS];
  assign out_pm    = pm_link[STEPS];
  assign out_pn    = pn_link[STEPS];
  assign out_ovf   = ovf_link[STEPS];
  assign out_side  = side_link[STEPS];

endmodule

// ----- sv/ppf_skid.sv -----
// output register with skid entry
module ppf_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  ppf_pkg::res_t up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output ppf_pkg::res_t dn_data
);
  import ppf_pkg::*;

  logic out_v_r, skid_v_r;
  res_t out_d_r, skid_d_r;
  logic up_take, out_free;

  assign up_ready = !skid_v_r;
  assign up_take  = up_valid && !skid_v_r;
  assign out_free = !out_v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= up_take;
      end
    end else if (up_take) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_d_r <= skid_v_r ? skid_d_r : up_data;
    end else if (up_take) begin
      skid_d_r <= up_data;
    end
  end

  assign dn_valid = out_v_r;
  assign dn_data  = out_d_r;

endmodule

// ----- sv/pair_potential_and_force.sv -----
// top level of the m-n pair potential and force core
//
// in_ beats carry one particle pair: species codes in tuser, distance r in
// tdata. out_ beats carry the energy and its slope du/dr in tdata and the
// saturation flag in tuser. cfg_ writes the six pair entries, the energy
// scale and the exponents; write it only while no beat is in flight.
// One pair enters every cycle while in_tready is high; results leave in
// order, one per pair. The pipeline depth comes from the power chain,
// two stages per multiply step, and the two radix-16 dividers (core/r
// and slope/r).
// Reset clears every valid bit and loads the register reset values.
// When the receiver stalls, the output register and a skid entry hold
// results; in_tready drops only once the skid entry is full, and the
// whole pipeline then holds with nothing lost or repeated.
module pair_potential_and_force_core #(
  parameter int DIST_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS  = 24,
  parameter int MAX_EXPONENT   = 31
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // distance
  input  logic [3:0]                 in_tuser,   // species_first, species_second
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [95:0]                out_tdata,  // energy, energy_slope
  output logic                       out_tuser,  // saturated
  input  logic                       cfg_we,
  input  logic [ppf_pkg::IDX_W-1:0]  cfg_index,
  input  logic [ppf_pkg::CFG_W-1:0]  cfg_wdata
);
  import ppf_pkg::*;

  localparam int XW       = 40 + DIST_FRAC_BITS;
  localparam int SH_X     = 20 + DIST_FRAC_BITS;
  localparam int TERM_SH  = 56 - OUT_FRAC_BITS;
  localparam int SIDE1_W  = 66;
  localparam int SIDE2_W  = 99;
  localparam int MAG_W    = 47;
  localparam int NW2      = 62 + DIST_FRAC_BITS;
  localparam int DIV_BPS  = 4;

  // configuration
  logic [PAIR_W-1:0]  pair_aa_r, pair_bb_r, pair_cc_r, pair_ab_r, pair_bc_r, pair_ca_r;
  logic [FIELD_W-1:0] scale_r;
  logic [9:0]         expo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_aa_r <= '0;
      pair_bb_r <= '0;
      pair_cc_r <= '0;
      pair_ab_r <= '0;
      pair_bc_r <= '0;
      pair_ca_r <= '0;
      scale_r   <= SCALE_RESET;
      expo_r    <= EXPO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAIR_AA:   pair_aa_r <= cfg_wdata;
        REG_PAIR_BB:   pair_bb_r <= cfg_wdata;
        REG_PAIR_CC:   pair_cc_r <= cfg_wdata;
        REG_PAIR_AB:   pair_ab_r <= cfg_wdata;
        REG_PAIR_BC:   pair_bc_r <= cfg_wdata;
        REG_PAIR_CA:   pair_ca_r <= cfg_wdata;
        REG_SCALE:     scale_r   <= cfg_wdata[FIELD_W-1:0];
        REG_EXPONENTS: expo_r    <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  logic [4:0] exp_m, exp_n;
  assign exp_m = (expo_r[9:5] > 5'(MAX_EXPONENT)) ? 5'(MAX_EXPONENT) : expo_r[9:5];
  assign exp_n = (expo_r[4:0] > 5'(MAX_EXPONENT)) ? 5'(MAX_EXPONENT) : expo_r[4:0];

  logic en;
  assign in_tready = en;

  // pair selection, cutoff test, scale product
  logic [1:0]         sp1, sp2;
  logic [DIST_W-1:0]  r_in;
  logic [PAIR_W-1:0]  entry;
  logic               in_cut;
  logic [39:0]        s_in;

  assign sp1  = in_tuser[1:0];
  assign sp2  = in_tuser[3:2];
  assign r_in = in_tdata;

  always_comb begin
    if (sp1 == sp2) begin
      if (sp1 == SPECIES_A)      entry = pair_aa_r;
      else if (sp1 == SPECIES_B) entry = pair_bb_r;
      else                       entry = pair_cc_r;
    end else if ((sp1 == SPECIES_A && sp2 == SPECIES_B) ||
                 (sp1 == SPECIES_B && sp2 == SPECIES_A)) begin
      entry = pair_ab_r;
    end else if ((sp1 == SPECIES_B && sp2 == SPECIES_C) ||
                 (sp1 == SPECIES_C && sp2 == SPECIES_B)) begin
      entry = pair_bc_r;
    end else begin
      entry = pair_ca_r;
    end
  end

  assign in_cut = (48'(r_in) << 12) < (48'(entry[59:40]) << DIST_FRAC_BITS);
  assign s_in   = entry[19:0] * scale_r;

  logic               v0_r;
  logic [DIST_W-1:0]  r0_r;
  logic [FIELD_W-1:0] core0_r;
  logic [39:0]        s0_r;
  logic               cut0_r, rz0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0_r    <= r_in;
      core0_r <= entry[39:20];
      s0_r    <= s_in;
      cut0_r  <= in_cut;
      rz0_r   <= (r_in == '0);
    end
  end

  // x = core / r in q32
  logic               d1_v;
  logic [XW-1:0]      x_q;
  logic [SIDE1_W-1:0] d1_side;

  ppf_divpipe #(
    .DEN_W (DIST_W),
    .Q_W   (XW),
    .BPS   (DIV_BPS),
    .SIDE_W(SIDE1_W)
  ) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v0_r),
    .in_rem   ('0),
    .in_lo    ({core0_r, {SH_X{1'b0}}}),
    .in_den   (r0_r),
    .in_side  ({r0_r, s0_r, cut0_r, rz0_r}),
    .out_valid(d1_v),
    .out_quot (x_q),
    .out_side (d1_side)
  );

  logic               pw_v, pw_ovf;
  logic [62:0]        pm, pn;
  logic [SIDE1_W-1:0] pw_side;

  ppf_powpipe #(
    .STEPS (MAX_EXPONENT),
    .SIDE_W(SIDE1_W)
  ) u_pow (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d1_v),
    .in_x     (64'(x_q)),
    .exp_m    (exp_m),
    .exp_n    (exp_n),
    .in_side  (d1_side),
    .out_valid(pw_v),
    .out_pm   (pm),
    .out_pn   (pn),
    .out_ovf  (pw_ovf),
    .out_side (pw_side)
  );

  logic [DIST_W-1:0] pw_r;
  logic [39:0]       pw_s;
  assign pw_r = pw_side[65:42];
  assign pw_s = pw_side[41:2];

  // term products, partial stage
  logic              v1_r, ovf1_r, sz1_r, cut1_r, rz1_r;
  logic [DIST_W-1:0] r1_r;
  logic [63:0]       a_ll_r, b_ll_r;
  logic [62:0]       a_lh_r, b_lh_r;
  logic [39:0]       a_hl_r, b_hl_r;
  logic [38:0]       a_hh_r, b_hh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_ll_r <= pw_s[31:0] * pm[31:0];
      a_lh_r <= pw_s[31:0] * pm[62:32];
      a_hl_r <= pw_s[39:32] * pm[31:0];
      a_hh_r <= pw_s[39:32] * pm[62:32];
      b_ll_r <= pw_s[31:0] * pn[31:0];
      b_lh_r <= pw_s[31:0] * pn[62:32];
      b_hl_r <= pw_s[39:32] * pn[31:0];
      b_hh_r <= pw_s[39:32] * pn[62:32];
      ovf1_r <= pw_ovf;
      sz1_r  <= (pw_s == '0);
      cut1_r <= pw_side[1];
      rz1_r  <= pw_side[0];
      r1_r   <= pw_r;
    end
  end

  // term products, sum and cap
  logic [127:0] a_prod, b_prod, a_q, b_q;
  logic         a_cap, b_cap;

  always_comb begin
    a_prod = 128'(a_ll_r) + (128'(a_lh_r) << 32) + (128'(a_hl_r) << 32) + (128'(a_hh_r) << 64);
    b_prod = 128'(b_ll_r) + (128'(b_lh_r) << 32) + (128'(b_hl_r) << 32) + (128'(b_hh_r) << 64);
    a_q    = a_prod >> TERM_SH;
    b_q    = b_prod >> TERM_SH;
    a_cap  = a_q > 128'(TERM_CAP);
    b_cap  = b_q > 128'(TERM_CAP);
  end

  logic              v2_r, ovf2_r, sz2_r, cut2_r, rz2_r;
  logic [DIST_W-1:0] r2_r;
  logic [56:0]       a2_r, b2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a2_r   <= a_cap ? TERM_CAP : a_q[56:0];
      b2_r   <= b_cap ? TERM_CAP : b_q[56:0];
      ovf2_r <= ovf1_r | a_cap | b_cap;
      sz2_r  <= sz1_r;
      cut2_r <= cut1_r;
      rz2_r  <= rz1_r;
      r2_r   <= r1_r;
    end
  end

  // exponent weighting and energy difference
  logic               v3_r, ovf3_r, sz3_r, cut3_r, rz3_r;
  logic [DIST_W-1:0]  r3_r;
  logic [61:0]        ma3_r, nb3_r;
  logic signed [57:0] ed3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ma3_r  <= a2_r * exp_m;
      nb3_r  <= b2_r * exp_n;
      ed3_r  <= signed'({1'b0, a2_r}) - signed'({1'b0, b2_r});
      ovf3_r <= ovf2_r;
      sz3_r  <= sz2_r;
      cut3_r <= cut2_r;
      rz3_r  <= rz2_r;
      r3_r   <= r2_r;
    end
  end

  // result class, energy clip, slope range test
  logic signed [63:0]     t_val, ed64;
  logic [63:0]            t_abs;
  logic [61:0]            d_nxt;
  logic                   big, neg_nxt;
  logic signed [OUT_W-1:0] e_nxt, sf_nxt, fix_e, fix_sf;
  logic                   ud_nxt, sat_nxt;

  always_comb begin
    t_val   = signed'(64'(ma3_r)) - signed'(64'(nb3_r));
    t_abs   = t_val[63] ? 64'(-t_val) : 64'(t_val);
    d_nxt   = t_abs[61:0];
    neg_nxt = (t_val > 0);
    ed64    = 64'(ed3_r);
    big     = 64'(d_nxt) >= (64'(r3_r) << (47 - DIST_FRAC_BITS));
    if (exp_m > exp_n) begin
      fix_e  = LIM47;
      fix_sf = NEG_LIM47;
    end else if (exp_m < exp_n) begin
      fix_e  = NEG_LIM47;
      fix_sf = LIM47;
    end else begin
      fix_e  = '0;
      fix_sf = '0;
    end
    e_nxt   = '0;
    sf_nxt  = '0;
    ud_nxt  = 1'b0;
    sat_nxt = 1'b0;
    if (!cut3_r) begin
      e_nxt = '0;
    end else if (rz3_r || (!sz3_r && ovf3_r && exp_m != exp_n)) begin
      e_nxt   = fix_e;
      sf_nxt  = fix_sf;
      sat_nxt = 1'b1;
    end else if (sz3_r) begin
      e_nxt = '0;
    end else begin
      if (ed64 > 64'(LIM47)) begin
        e_nxt   = LIM47;
        sat_nxt = 1'b1;
      end else if (ed64 < 64'(NEG_LIM47)) begin
        e_nxt   = NEG_LIM47;
        sat_nxt = 1'b1;
      end else begin
        e_nxt = ed64[OUT_W-1:0];
      end
      if (big) begin
        sf_nxt  = neg_nxt ? NEG_LIM47 : LIM47;
        sat_nxt = 1'b1;
      end else begin
        ud_nxt = 1'b1;
      end
    end
  end

  logic                    v4_r, ud4_r, neg4_r, sat4_r;
  logic [61:0]             d4_r;
  logic [DIST_W-1:0]       r4_r;
  logic signed [OUT_W-1:0] e4_r, sf4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= pw_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d4_r   <= d_nxt;
      r4_r   <= r3_r;
      e4_r   <= e_nxt;
      sf4_r  <= sf_nxt;
      ud4_r  <= ud_nxt;
      neg4_r <= neg_nxt;
      sat4_r <= sat_nxt;
    end
  end

  // slope magnitude = d * 2^frac / r
  logic [NW2-1:0]     dsh;
  logic               d2_v;
  logic [MAG_W-1:0]   mag_q;
  logic [SIDE2_W-1:0] d2_side;

  assign dsh = {d4_r, {DIST_FRAC_BITS{1'b0}}};

  ppf_divpipe #(
    .DEN_W (DIST_W),
    .Q_W   (MAG_W),
    .BPS   (DIV_BPS),
    .SIDE_W(SIDE2_W)
  ) u_div_slope (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v4_r),
    .in_rem   (DIST_W'(dsh >> MAG_W)),
    .in_lo    (dsh[MAG_W-1:0]),
    .in_den   (r4_r),
    .in_side  ({e4_r, sf4_r, ud4_r, neg4_r, sat4_r}),
    .out_valid(d2_v),
    .out_quot (mag_q),
    .out_side (d2_side)
  );

  logic signed [OUT_W-1:0] mag_s;
  res_t fin, dn;

  assign mag_s = signed'({1'b0, mag_q});

  always_comb begin
    fin.energy = d2_side[98:51];
    fin.sat    = d2_side[0];
    if (d2_side[2]) begin
      fin.slope = d2_side[1] ? -mag_s : mag_s;
    end else begin
      fin.slope = d2_side[50:3];
    end
  end

  ppf_skid u_skid (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(d2_v),
    .up_ready(en),
    .up_data (fin),
    .dn_valid(out_tvalid),
    .dn_ready(out_tready),
    .dn_data (dn)
  );

  assign out_tdata = {dn.slope, dn.energy};
  assign out_tuser = dn.sat;

endmodule

// ----- dv/pair_potential_and_force_core_test.sv -----
// self-checking testbench for the m-n pair potential and force core
module pair_potential_and_force_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ppf_pkg::*;

  localparam int LATENCY = 94;
  localparam int LIMIT = 600000;

  typedef struct {
    logic [1:0]  sp_first;
    logic [1:0]  sp_second;
    logic [23:0] sep;
    bit          drain;
  } pair_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [23:0] in_tdata = '0;
  logic [3:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [95:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  logic [59:0] pair_tab [6];
  logic [19:0] scale;
  logic [9:0] expo;

  pair_t pending[$];
  res_t expected_beats[$];
  bit in_fired, out_fired;
  bit send_calm, recv_calm;
  int send_gap, recv_stall;
  int errors, checked, sat_seen, cycles, phases;

  pair_potential_and_force_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] scaled_product(logic [63:0] p, logic [63:0] q, int k,
                                                 logic [63:0] cap, inout bit ovf);
    logic [127:0] prod;
    prod = ({64'b0, p} * {64'b0, q}) >> k;
    if (prod > {64'b0, cap}) begin
      ovf = 1'b1;
      return cap;
    end
    return prod[63:0];
  endfunction

  function automatic logic [63:0] raise(logic [63:0] x, int unsigned e, inout bit ovf);
    logic [63:0] p;
    p = 64'd1 << 32;
    for (int i = 0; i < e; i++) p = scaled_product(p, x, 32, {1'b0, POW_CAP}, ovf);
    return p;
  endfunction

  function automatic res_t pair_response(logic [1:0] sa, logic [1:0] sb, logic [23:0] r);
    logic [59:0] entry;
    logic [19:0] eps, core, cut;
    int unsigned m, n;
    logic [63:0] s, x, pm, pn, a, b, d, mag, lim;
    logic [127:0] q;
    longint t, en, sl;
    bit ovf, sat;
    res_t res;
    lim = 64'(LIM47);
    if (sa == sb) entry = sa == SPECIES_A ? pair_tab[REG_PAIR_AA] :
                          sa == SPECIES_B ? pair_tab[REG_PAIR_BB] : pair_tab[REG_PAIR_CC];
    else if ({sa, sb} == {SPECIES_A, SPECIES_B} || {sa, sb} == {SPECIES_B, SPECIES_A})
      entry = pair_tab[REG_PAIR_AB];
    else if ({sa, sb} == {SPECIES_B, SPECIES_C} || {sa, sb} == {SPECIES_C, SPECIES_B})
      entry = pair_tab[REG_PAIR_BC];
    else entry = pair_tab[REG_PAIR_CA];
    eps = entry[19:0];
    core = entry[39:20];
    cut = entry[59:40];
    m = expo[9:5];
    n = expo[4:0];
    en = 0;
    sl = 0;
    ovf = 1'b0;
    sat = 1'b0;
    if ((64'(r) << 12) < (64'(cut) << 16)) begin
      s = 64'(eps) * 64'(scale);
      if (r == 0) begin
        ovf = 1'b1;
        sat = 1'b1;
      end else if (s != 0) begin
        x = (64'(core) << 36) / r;
        pm = raise(x, m, ovf);
        pn = raise(x, n, ovf);
        a = scaled_product(s, pm, 32, {7'b0, TERM_CAP}, ovf);
        b = scaled_product(s, pn, 32, {7'b0, TERM_CAP}, ovf);
        if (!ovf || m == n) begin
          t = $signed(64'(m) * a) - $signed(64'(n) * b);
          d = t < 0 ? -t : t;
          ovf = 1'b0;
          en = $signed(a) - $signed(b);
          if (en > $signed(lim)) begin
            en = lim;
            sat = 1'b1;
          end else if (en < -$signed(lim)) begin
            en = -$signed(lim);
            sat = 1'b1;
          end
          if ({64'b0, d} >= ({104'b0, r} << 31)) begin
            mag = lim;
            sat = 1'b1;
          end else begin
            q = ({64'b0, d} << 16) / r;
            mag = q[63:0];
            if (mag > lim) begin
              mag = lim;
              sat = 1'b1;
            end
          end
          sl = t > 0 ? -$signed(mag) : $signed(mag);
        end else begin
          sat = 1'b1;
        end
      end
      if (ovf) begin
        if (m > n) begin
          en = lim;
          sl = -$signed(lim);
        end else if (m < n) begin
          en = -$signed(lim);
          sl = lim;
        end else begin
          en = 0;
          sl = 0;
        end
      end
    end
    res.energy = en[47:0];
    res.slope = sl[47:0];
    res.sat = sat;
    return res;
  endfunction

  task automatic report(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // beat monitor and scoreboard
  always @(posedge clk) begin
    res_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
    out_fired <= rst_n && out_tvalid && out_tready;
    in_fired <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_beats.size() == 0) begin
        report("unexpected beat", out_tdata[47:0], 48'd0);
      end else begin
        want = expected_beats.pop_front();
        checked++;
        if (out_tuser) sat_seen++;
        if (out_tdata[47:0] !== want.energy) report("energy", out_tdata[47:0], want.energy);
        if (out_tdata[95:48] !== want.slope) report("slope", out_tdata[95:48], want.slope);
        if (out_tuser !== want.sat) report("saturated", 48'(out_tuser), 48'(want.sat));
      end
    end
    if (rst_n && in_tvalid && in_tready)
      expected_beats.push_back(pair_response(in_tuser[1:0], in_tuser[3:2], in_tdata));
  end

  // input driver
  always @(negedge clk) begin
    pair_t item;
    logic nxt_valid;
    nxt_valid = 1'b0;
    if (!rst_n) begin
      send_gap = 0;
    end else if (in_tvalid && !in_fired) begin
      nxt_valid = 1'b1;
    end else if (send_gap > 0) begin
      send_gap--;
    end else if (pending.size() != 0 &&
                 (!pending[0].drain || expected_beats.size() == 0)) begin
      item = pending.pop_front();
      in_tdata <= item.sep;
      in_tuser <= {item.sp_second, item.sp_first};
      nxt_valid = 1'b1;
      send_gap = send_calm ? 0 : $urandom_range(0, 18);
    end
    in_tvalid <= nxt_valid;
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_fired) recv_stall = recv_calm ? 0 : $urandom_range(0, 18);
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_SCALE) scale = value[19:0];
    else if (idx == REG_EXPONENTS) expo = value[9:0];
    else pair_tab[idx] = value[59:0];
    @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    cfg_we <= 1'b0;
    while (pending.size() != 0 || in_tvalid || expected_beats.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic add_pair(logic [1:0] sa, logic [1:0] sb, logic [23:0] r, bit drain);
    pair_t item;
    item.sp_first = sa;
    item.sp_second = sb;
    item.sep = r;
    item.drain = drain;
    pending.push_back(item);
  endtask

  function automatic logic [59:0] random_entry();
    logic [19:0] core, cut;
    if ($urandom_range(0, 7) == 0) begin
      core = $urandom();
      cut = $urandom();
    end else begin
      core = $urandom_range(2048, 8192);
      cut = core * $urandom_range(2, 5) + $urandom_range(0, 4095);
    end
    return {cut, core, 20'($urandom())};
  endfunction

  task automatic random_setup();
    logic [9:0] ex;
    logic [19:0] sc;
    case ($urandom_range(0, 5))
      0: ex = EXPO_RESET;
      1: ex = 10'd0;
      2: ex = 10'h3FF;
      3: ex = {5'd6, 5'd12};
      default: ex = $urandom();
    endcase
    case ($urandom_range(0, 4))
      0: sc = 20'd0;
      1: sc = 20'hFFFFF;
      2: sc = SCALE_RESET;
      default: sc = $urandom();
    endcase
    for (int i = 0; i < 6; i++) write_reg(IDX_W'(i), 60'(random_entry()));
    write_reg(REG_SCALE, 60'(sc));
    write_reg(REG_EXPONENTS, 60'(ex));
  endtask

  function automatic logic [23:0] pick_dist(logic [1:0] sa, logic [1:0] sb);
    logic [59:0] entry;
    logic [31:0] lo, hi;
    entry = pair_tab[REG_PAIR_CA];
    if (sa == sb)
      entry = sa == SPECIES_A ? pair_tab[REG_PAIR_AA] :
              sa == SPECIES_B ? pair_tab[REG_PAIR_BB] : pair_tab[REG_PAIR_CC];
    lo = 32'(entry[39:20]) << 3;
    hi = (32'(entry[59:40]) << 4) + 32'd64;
    if (hi > 32'hFFFFFF) hi = 32'hFFFFFF;
    if (lo >= hi) lo = 0;
    case ($urandom_range(0, 19))
      0: return 24'd0;
      1: return 24'($urandom_range(1, 255));
      2, 3, 4, 5: return 24'($urandom());
      6: return 24'((32'(entry[59:40]) << 4) - 32'd1 + 32'($urandom_range(0, 2)));
      default: return 24'($urandom_range(lo, hi));
    endcase
  endfunction

  initial begin
    logic [1:0] sa, sb;
    for (int i = 0; i < 6; i++) pair_tab[i] = '0;
    scale = SCALE_RESET;
    expo = EXPO_RESET;
    send_calm = 1'b0;
    recv_calm = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: every entry empty, so all beats fall outside the cutoff
    add_pair(SPECIES_A, SPECIES_A, 24'h010000, 1'b0);
    add_pair(SPECIES_C, SPECIES_B, 24'd0, 1'b0);
    settle();

    // directed: every species pairing, zero and extreme distances, cutoff edge
    write_reg(REG_PAIR_AA, {20'h04000, 20'h01000, 20'h00800});
    write_reg(REG_PAIR_BB, {20'h06000, 20'h01400, 20'h01000});
    write_reg(REG_PAIR_CC, {20'h08000, 20'h01800, 20'h02000});
    write_reg(REG_PAIR_AB, {20'h05000, 20'h01200, 20'h00C00});
    write_reg(REG_PAIR_BC, {20'h07000, 20'h01600, 20'h01800});
    write_reg(REG_PAIR_CA, {20'hFFFFF, 20'h01100, 20'h03000});
    for (int i = 0; i < 16; i++) add_pair(2'(i), 2'(i >> 2), 24'h012000, 1'b0);
    add_pair(SPECIES_A, SPECIES_A, 24'd0, 1'b0);
    add_pair(SPECIES_A, SPECIES_A, 24'd1, 1'b0);
    add_pair(SPECIES_A, SPECIES_A, 24'hFFFFFF, 1'b0);
    add_pair(SPECIES_A, SPECIES_A, 24'h03FFFF, 1'b0);
    add_pair(SPECIES_A, SPECIES_A, 24'h040000, 1'b0);
    add_pair(SPECIES_C, SPECIES_A, 24'h008000, 1'b0);
    settle();

    // extremes: scale zero, then all-ones entries with the largest exponents
    write_reg(REG_SCALE, 60'd0);
    add_pair(SPECIES_B, SPECIES_B, 24'h010000, 1'b0);
    add_pair(SPECIES_B, SPECIES_B, 24'd0, 1'b0);
    settle();
    for (int i = 0; i < 6; i++) write_reg(IDX_W'(i), '1);
    write_reg(REG_SCALE, 60'hFFFFF);
    write_reg(REG_EXPONENTS, 60'h3FF);
    add_pair(SPECIES_A, SPECIES_B, 24'd1, 1'b0);
    add_pair(SPECIES_B, SPECIES_C, 24'hFFFFFF, 1'b0);
    add_pair(SPECIES_C, SPECIES_C, 24'd0, 1'b0);
    settle();
    phases = 4;

    for (int ph = 0; ph < 8; ph++) begin
      random_setup();
      send_calm = $urandom_range(0, 3) == 0;
      recv_calm = $urandom_range(0, 3) == 0;
      for (int k = 0; k < 150; k++) begin
        sa = $urandom_range(0, 9) == 0 ? 2'd0 : 2'($urandom_range(1, 3));
        sb = $urandom_range(0, 9) == 0 ? 2'd0 : 2'($urandom_range(1, 3));
        add_pair(sa, sb, pick_dist(sa, sb), k == 75 || $urandom_range(0, 99) == 0);
      end
      settle();
      phases++;
    end

    $display("checked %0d result beats over %0d register settings, %0d saturated",
             checked, phases, sat_seen);
    $display("species codes 0..3, zero, cutoff-edge and full-range distances covered");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- pair_potential_and_force_core.f -----
sv/ppf_pkg.sv
sv/ppf_divpipe.sv
sv/ppf_powpipe.sv
sv/ppf_skid.sv
sv/pair_potential_and_force.sv
dv/pair_potential_and_force_core_test.sv
